/* hdl/tsdrt_pkg.sv */
// shared types and constants of the tile store dirty rectangle tracker
package tsdrt_pkg;

	localparam int MAX_COLUMNS_DEF = 128;
	localparam int MAX_ROWS_DEF    = 128;
	localparam int TILE_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH     = 4;

	localparam int MODE_W     = 2;
	localparam int COORD_W    = 11;
	localparam int VALUE_W    = 16;
	localparam int MAP_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;
	localparam int RECT_POS_W = 7;
	localparam int RECT_LEN_W = 8;

	localparam logic [MAP_W-1:0] MAP_SIZE_RST = 8'd128;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_TILE = 2'd2;

	typedef enum logic [MODE_W-1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_MARK  = 2'd3
	} op_t;

	typedef struct packed {
		op_t  op;
		logic in_bounds;
	} tsdrt_ctl_t;

endpackage

/* hdl/tsdrt_fifo.sv */
// small register queue between the front and back parts
module tsdrt_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] head_data,
	output logic         empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("pop from empty queue");
`endif

endmodule

/* hdl/tsdrt_front.sv */
// front part: accepts words, checks bounds and forms the store address
module tsdrt_front #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 128,
	parameter int TILE_BITS   = 16,
	parameter int ENTRY_W     = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          hold,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tsdrt_pkg::MODE_W-1:0]  in_mode,
	input  logic [tsdrt_pkg::COORD_W-1:0] in_x,
	input  logic [tsdrt_pkg::COORD_W-1:0] in_y,
	input  logic [tsdrt_pkg::VALUE_W-1:0] in_value,
	input  logic [tsdrt_pkg::COORD_W-1:0] eff_w,
	input  logic [tsdrt_pkg::COORD_W-1:0] eff_h,
	output logic                          push,
	output logic [ENTRY_W-1:0]            push_data,
	input  logic                          full
);
	import tsdrt_pkg::*;

	localparam int XW = $clog2(MAX_COLUMNS);
	localparam int YW = $clog2(MAX_ROWS);
	localparam int AW = $clog2(MAX_COLUMNS * MAX_ROWS);

	tsdrt_ctl_t           ctl_c;
	logic [XW-1:0]        x_c;
	logic [YW-1:0]        y_c;
	logic [AW-1:0]        addr_c;
	logic [TILE_BITS-1:0] val_c;
	logic                 accept;

	logic                 valid_s1;
	tsdrt_ctl_t           ctl_s1;
	logic [AW-1:0]        addr_s1;
	logic [XW-1:0]        x_s1;
	logic [YW-1:0]        y_s1;
	logic [TILE_BITS-1:0] val_s1;

	always_comb begin
		ctl_c.op        = op_t'(in_mode);
		ctl_c.in_bounds = !in_x[COORD_W-1] && !in_y[COORD_W-1] &&
		                  ({1'b0, in_x[COORD_W-2:0]} < eff_w) &&
		                  ({1'b0, in_y[COORD_W-2:0]} < eff_h);
		x_c    = in_x[XW-1:0];
		y_c    = in_y[YW-1:0];
		addr_c = AW'(y_c) * AW'(MAX_COLUMNS) + AW'(x_c);
		val_c  = TILE_BITS'(in_value);
	end

	assign in_ready  = !hold && (!valid_s1 || !full);
	assign accept    = in_valid && in_ready;
	assign push      = valid_s1 && !full;
	assign push_data = {ctl_s1, addr_s1, x_s1, y_s1, val_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1  <= ctl_c;
			addr_s1 <= addr_c;
			x_s1    <= x_c;
			y_s1    <= y_c;
			val_s1  <= val_c;
		end
	end

endmodule

/* hdl/tsdrt_back.sv */
// back part: tile memory, dirty rectangle and output register
module tsdrt_back #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 128,
	parameter int TILE_BITS   = 16,
	parameter int ENTRY_W     = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [ENTRY_W-1:0]               head_data,
	input  logic                             empty,
	output logic                             pop,
	input  logic [tsdrt_pkg::COORD_W-1:0]    eff_w,
	input  logic [tsdrt_pkg::COORD_W-1:0]    eff_h,
	input  logic [TILE_BITS-1:0]             empty_tile,
	output logic                             clearing,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tsdrt_pkg::OUT_DATA_W-1:0] out_data
);
	import tsdrt_pkg::*;

	localparam int XW    = $clog2(MAX_COLUMNS);
	localparam int YW    = $clog2(MAX_ROWS);
	localparam int SXW   = $clog2(MAX_COLUMNS + 1);
	localparam int SYW   = $clog2(MAX_ROWS + 1);
	localparam int HXW   = SXW + 1;
	localparam int HYW   = SYW + 1;
	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RST_W = (MAX_COLUMNS < 128) ? MAX_COLUMNS : 128;
	localparam int RST_H = (MAX_ROWS < 128) ? MAX_ROWS : 128;

	logic [TILE_BITS-1:0] mem [DEPTH];

	tsdrt_ctl_t           q_ctl;
	logic [AW-1:0]        q_addr;
	logic [XW-1:0]        q_x;
	logic [YW-1:0]        q_y;
	logic [TILE_BITS-1:0] q_val;

	logic                 valid_s2;
	tsdrt_ctl_t           ctl_s2;
	logic [AW-1:0]        addr_s2;
	logic [XW-1:0]        x_s2;
	logic [YW-1:0]        y_s2;
	logic [TILE_BITS-1:0] val_s2;
	logic [TILE_BITS-1:0] rdata_s2;
	logic                 fwd_hit_s2;
	logic [TILE_BITS-1:0] fwd_data_s2;

	logic                 clearing_q;
	logic [AW-1:0]        clr_addr_q;

	logic                 dirty_q;
	logic [XW-1:0]        left_q;
	logic [YW-1:0]        top_q;
	logic [SXW-1:0]       span_x_q;
	logic [SYW-1:0]       span_y_q;

	logic                 out_valid_q;
	logic [VALUE_W-1:0]   out_tile_q;
	logic                 out_dirty_q;
	logic [RECT_POS_W-1:0] out_x_q;
	logic [RECT_POS_W-1:0] out_y_q;
	logic [RECT_LEN_W-1:0] out_w_q;
	logic [RECT_LEN_W-1:0] out_h_q;

	logic                 s2_fire;
	logic [TILE_BITS-1:0] cur;
	logic                 wr_chg;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [TILE_BITS-1:0] mem_wdata;

	logic                 dirty_n;
	logic [XW-1:0]        left_n;
	logic [YW-1:0]        top_n;
	logic [SXW-1:0]       span_x_n;
	logic [SYW-1:0]       span_y_n;
	logic [TILE_BITS-1:0] rd_n;
	logic [XW-1:0]        lo_x;
	logic [YW-1:0]        lo_y;
	logic [HXW-1:0]       hi_x;
	logic [HYW-1:0]       hi_y;
	logic [HXW-1:0]       xp1;
	logic [HYW-1:0]       yp1;

	assign {q_ctl, q_addr, q_x, q_y, q_val} = head_data;

	assign s2_fire  = valid_s2 && (!out_valid_q || out_ready);
	assign pop      = !empty && !clearing_q && (!valid_s2 || s2_fire);
	assign clearing = clearing_q;

	assign cur       = fwd_hit_s2 ? fwd_data_s2 : rdata_s2;
	assign wr_chg    = (ctl_s2.op == OP_WRITE) && ctl_s2.in_bounds && (cur != val_s2);
	assign mem_we    = clearing_q || (s2_fire && wr_chg);
	assign mem_waddr = clearing_q ? clr_addr_q : addr_s2;
	assign mem_wdata = clearing_q ? '0 : val_s2;

	always_comb begin
		dirty_n  = dirty_q;
		left_n   = left_q;
		top_n    = top_q;
		span_x_n = span_x_q;
		span_y_n = span_y_q;
		rd_n     = '0;
		lo_x     = (left_q < x_s2) ? left_q : x_s2;
		lo_y     = (top_q < y_s2) ? top_q : y_s2;
		xp1      = HXW'(x_s2) + 1'b1;
		yp1      = HYW'(y_s2) + 1'b1;
		hi_x     = HXW'(left_q) + HXW'(span_x_q);
		hi_y     = HYW'(top_q) + HYW'(span_y_q);
		if (xp1 > hi_x) begin
			hi_x = xp1;
		end
		if (yp1 > hi_y) begin
			hi_y = yp1;
		end
		case (ctl_s2.op)
			OP_WRITE: begin
				if (wr_chg) begin
					dirty_n = 1'b1;
					if (!dirty_q) begin
						left_n   = x_s2;
						top_n    = y_s2;
						span_x_n = SXW'(1);
						span_y_n = SYW'(1);
					end else begin
						left_n   = lo_x;
						top_n    = lo_y;
						span_x_n = SXW'(hi_x - HXW'(lo_x));
						span_y_n = SYW'(hi_y - HYW'(lo_y));
					end
				end
			end
			OP_READ: begin
				rd_n = ctl_s2.in_bounds ? cur : empty_tile;
			end
			OP_CLEAR: begin
				dirty_n  = 1'b0;
				left_n   = '0;
				top_n    = '0;
				span_x_n = '0;
				span_y_n = '0;
			end
			OP_MARK: begin
				dirty_n  = 1'b1;
				left_n   = '0;
				top_n    = '0;
				span_x_n = SXW'(eff_w);
				span_y_n = SYW'(eff_h);
			end
			default: begin
				rd_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (pop) begin
			rdata_s2 <= mem[q_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_s2      <= q_ctl;
			addr_s2     <= q_addr;
			x_s2        <= q_x;
			y_s2        <= q_y;
			val_s2      <= q_val;
			fwd_data_s2 <= val_s2;
		end
		if (s2_fire) begin
			out_tile_q  <= VALUE_W'(rd_n);
			out_dirty_q <= dirty_n;
			out_x_q     <= RECT_POS_W'(left_n);
			out_y_q     <= RECT_POS_W'(top_n);
			out_w_q     <= RECT_LEN_W'(span_x_n);
			out_h_q     <= RECT_LEN_W'(span_y_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			fwd_hit_s2  <= 1'b0;
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			dirty_q     <= 1'b1;
			left_q      <= '0;
			top_q       <= '0;
			span_x_q    <= SXW'(RST_W);
			span_y_q    <= SYW'(RST_H);
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (pop) begin
				valid_s2   <= 1'b1;
				fwd_hit_s2 <= s2_fire && wr_chg && (addr_s2 == q_addr);
			end else if (s2_fire) begin
				valid_s2 <= 1'b0;
			end
			if (s2_fire) begin
				dirty_q     <= dirty_n;
				left_q      <= left_n;
				top_q       <= top_n;
				span_x_q    <= span_x_n;
				span_y_q    <= span_y_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {1'b0, out_h_q, out_w_q, out_y_q, out_x_q, out_dirty_q, out_tile_q};

`ifndef SYNTHESIS
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !pop) else $error("item taken during clearing pass");
	a_fire_shows: assert property (@(posedge clk) disable iff (!arst_n)
		s2_fire |=> out_valid_q) else $error("result lost after execution");
	a_clean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!dirty_q |-> (span_x_q == '0 && span_y_q == '0 && left_q == '0 && top_q == '0))
		else $error("clean map with nonzero rectangle");
	a_rect_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(HXW'(left_q) + HXW'(span_x_q) <= HXW'(MAX_COLUMNS)) &&
		(HYW'(top_q) + HYW'(span_y_q) <= HYW'(MAX_ROWS)))
		else $error("dirty rectangle beyond store");
`endif

endmodule

/* hdl/tile_store_dirty_rect_tracker.sv */
// top level of the tile store with dirty rectangle tracking
//
// input words arrive on s_axis: tuser carries the operation (write, read,
// clear dirty, mark all dirty), tdata the signed position and tile value.
// every word gives exactly one result word on m_axis with the read tile,
// the dirty flag and the dirty rectangle after that operation.
// the user must set map size and empty tile over the cfg channel only while the
// block is idle; the block itself does not enforce this. a word passes an input
// register, a four-entry queue, the memory read stage and the output register.
// one word per cycle is sustained if m_axis_tready is high; the tile memory has
// one read and one write port, with a bypass for back-to-back words on a tile.
// after reset the tile memory is swept to zero, one entry per cycle, over all
// MAX_COLUMNS * MAX_ROWS entries (16384 by default); s_axis_tready stays low
// during the sweep. the whole map starts dirty.
// when m_axis_tready is low the result is held, the queue fills, and then
// s_axis_tready drops; no word is lost.
module tile_store_dirty_rect_tracker #(
	parameter int MAX_COLUMNS = tsdrt_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tsdrt_pkg::MAX_ROWS_DEF,
	parameter int TILE_BITS   = tsdrt_pkg::TILE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// pos_x, pos_y, tile_value
	input  logic [tsdrt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic [tsdrt_pkg::MODE_W-1:0]     s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// read_tile, dirty_flag, rect_x, rect_y, rect_width, rect_height
	output logic [tsdrt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tsdrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsdrt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tsdrt_pkg::*;

	localparam int XW      = $clog2(MAX_COLUMNS);
	localparam int YW      = $clog2(MAX_ROWS);
	localparam int AW      = $clog2(MAX_COLUMNS * MAX_ROWS);
	localparam int ENTRY_W = $bits(tsdrt_ctl_t) + AW + XW + YW + TILE_BITS;

	logic [MAP_W-1:0]     map_width_q;
	logic [MAP_W-1:0]     map_height_q;
	logic [TILE_BITS-1:0] empty_tile_q;
	logic [COORD_W-1:0]   eff_w;
	logic [COORD_W-1:0]   eff_h;

	logic                 hold;
	logic                 push;
	logic                 pop;
	logic                 full;
	logic                 empty;
	logic [ENTRY_W-1:0]   push_data;
	logic [ENTRY_W-1:0]   head_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_SIZE_RST;
			map_height_q <= MAP_SIZE_RST;
			empty_tile_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAP_WIDTH:  map_width_q  <= cfg_data[MAP_W-1:0];
				CFG_MAP_HEIGHT: map_height_q <= cfg_data[MAP_W-1:0];
				CFG_EMPTY_TILE: empty_tile_q <= TILE_BITS'(cfg_data);
				default: begin
					empty_tile_q <= empty_tile_q;
				end
			endcase
		end
	end

	assign eff_w = (COORD_W'(map_width_q) > COORD_W'(MAX_COLUMNS)) ?
	               COORD_W'(MAX_COLUMNS) : COORD_W'(map_width_q);
	assign eff_h = (COORD_W'(map_height_q) > COORD_W'(MAX_ROWS)) ?
	               COORD_W'(MAX_ROWS) : COORD_W'(map_height_q);

	tsdrt_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.TILE_BITS   (TILE_BITS),
		.ENTRY_W     (ENTRY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (hold),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.in_x      (s_axis_tdata[10:0]),
		.in_y      (s_axis_tdata[21:11]),
		.in_value  (s_axis_tdata[37:22]),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	tsdrt_fifo #(
		.W     (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head_data (head_data),
		.empty     (empty)
	);

	tsdrt_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.TILE_BITS   (TILE_BITS),
		.ENTRY_W     (ENTRY_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_data  (head_data),
		.empty      (empty),
		.pop        (pop),
		.eff_w      (eff_w),
		.eff_h      (eff_h),
		.empty_tile (empty_tile_q),
		.clearing   (hold),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata)
	);

endmodule

/* sim/tb_top.sv */
// self-checking testbench of the tile store dirty rectangle tracker, directed table then random phases
module tb_top;
	import tsdrt_pkg::*;

	localparam int TIMEOUT_CYCLES = 600000;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 20;
	localparam int PRESSURE_AT    = 720;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASES         = 8;
	localparam int PHASE_WORDS    = 166;
	localparam int STORE_COLS     = MAX_COLUMNS_DEF;
	localparam int STORE_ROWS     = MAX_ROWS_DEF;

	// fields of one result word, highest bits first
	typedef struct packed {
		logic        pad;
		logic [7:0]  rect_height;
		logic [7:0]  rect_width;
		logic [6:0]  rect_y;
		logic [6:0]  rect_x;
		logic        dirty_flag;
		logic [15:0] read_tile;
	} tile_view_t;

	typedef enum bit {ROW_WORD, ROW_REG} row_kind_e;

	typedef struct {
		row_kind_e            kind;
		op_t                  op;
		int                   x;
		int                   y;
		logic [15:0]          data;
		logic [CFG_IDX_W-1:0] reg_idx;
		bit                   typed;
		tile_view_t           view;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [MODE_W-1:0]     s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// typed expectation riding along with the word on the input
	logic       tx_typed;
	tile_view_t tx_view;

	tile_store_dirty_rect_tracker u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// shadow of the block
	logic [15:0] tile_mem [0:STORE_COLS*STORE_ROWS-1];
	int unsigned map_w_reg = 128;
	int unsigned map_h_reg = 128;
	logic [15:0] empty_reg = '0;
	int          d_bit     = 1;
	int          d_left    = 0;
	int          d_top     = 0;
	int          d_span_x  = 128;
	int          d_span_y  = 128;

	tile_view_t expected_views [$];
	dir_row_t   dir_rows [$];

	int error_count   = 0;
	int checked_count = 0;
	int accepted_in   = 0;
	int regs_written  = 0;
	int bp_cycles     = 0;
	int tx_idle_pct   = 0;
	int rx_stall_pct  = 0;

	int unsigned hold_left     = 0;
	bit          pressure_done = 0;

	function automatic tile_view_t apply_tile_op(op_t op, logic signed [10:0] px,
			logic signed [10:0] py, logic [15:0] val);
		tile_view_t r;
		int ew, eh, ix, iy, lo_x, lo_y, hi_x, hi_y, idx;
		bit in_map;
		ew = (map_w_reg > STORE_COLS) ? STORE_COLS : map_w_reg;
		eh = (map_h_reg > STORE_ROWS) ? STORE_ROWS : map_h_reg;
		ix = px;
		iy = py;
		in_map = ix >= 0 && iy >= 0 && ix < ew && iy < eh;
		idx = in_map ? iy * STORE_COLS + ix : 0;
		r = '0;
		case (op)
			OP_WRITE: begin
				if (in_map && tile_mem[idx] != val) begin
					tile_mem[idx] = val;
					if (d_bit == 0) begin
						d_bit = 1;
						d_left = ix;
						d_top = iy;
						d_span_x = 1;
						d_span_y = 1;
					end else begin
						lo_x = (d_left < ix) ? d_left : ix;
						lo_y = (d_top < iy) ? d_top : iy;
						hi_x = d_left + d_span_x;
						hi_y = d_top + d_span_y;
						if (ix + 1 > hi_x) hi_x = ix + 1;
						if (iy + 1 > hi_y) hi_y = iy + 1;
						d_left = lo_x;
						d_top = lo_y;
						d_span_x = hi_x - lo_x;
						d_span_y = hi_y - lo_y;
					end
				end
			end
			OP_READ: begin
				r.read_tile = in_map ? tile_mem[idx] : empty_reg;
			end
			OP_CLEAR: begin
				d_bit = 0;
				d_left = 0;
				d_top = 0;
				d_span_x = 0;
				d_span_y = 0;
			end
			default: begin
				d_bit = 1;
				d_left = 0;
				d_top = 0;
				d_span_x = ew;
				d_span_y = eh;
			end
		endcase
		r.dirty_flag  = d_bit[0];
		r.rect_x      = d_left[6:0];
		r.rect_y      = d_top[6:0];
		r.rect_width  = d_span_x[7:0];
		r.rect_height = d_span_y[7:0];
		return r;
	endfunction

	function automatic tile_view_t view(logic [15:0] rd, logic df, int rx, int ry,
			int rw, int rh);
		tile_view_t r;
		r = '0;
		r.read_tile   = rd;
		r.dirty_flag  = df;
		r.rect_x      = rx[6:0];
		r.rect_y      = ry[6:0];
		r.rect_width  = rw[7:0];
		r.rect_height = rh[7:0];
		return r;
	endfunction

	function automatic void add_word(op_t op, int x, int y, logic [15:0] v, bit typed,
			tile_view_t res);
		dir_row_t row;
		row.kind    = ROW_WORD;
		row.op      = op;
		row.x       = x;
		row.y       = y;
		row.data    = v;
		row.reg_idx = '0;
		row.typed   = typed;
		row.view    = res;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
		dir_row_t row;
		row.kind    = ROW_REG;
		row.op      = OP_READ;
		row.x       = 0;
		row.y       = 0;
		row.data    = v;
		row.reg_idx = idx;
		row.typed   = 0;
		row.view    = '0;
		dir_rows.push_back(row);
	endfunction

	function automatic int pick_coord(int lim);
		int r;
		r = $urandom_range(19);
		if (lim == 0) return $urandom_range(3);
		if (r == 0) return lim;
		if (r == 1) return -1;
		return $urandom_range(lim - 1);
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch %s: got %0h want %0h at result %0d", what, got, want,
			checked_count);
		error_count++;
	endtask

	task automatic drive_word(op_t op, int x, int y, logic [15:0] v, bit typed,
			tile_view_t res);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {2'b00, v, 11'(y), 11'(x)};
		tx_typed      <= typed;
		tx_view       <= res;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_views.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * 10);
		$display("timeout after %0d cycles", TIMEOUT_CYCLES);
		$display("status: fail");
		$finish;
	end

	// receiver: random stalls plus one long hold once PRESSURE_AT input words are accepted
	always @(posedge clk) begin
		if (hold_left == 0 && !pressure_done && accepted_in >= PRESSURE_AT) begin
			hold_left = HOLD_CYCLES;
			pressure_done = 1;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// monitor: check results, then predict accepted words and register writes
	always @(posedge clk) begin
		tile_view_t got;
		tile_view_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_views.size() == 0) begin
					report_mismatch("result with nothing pending", 32'(got), 0);
				end else begin
					want = expected_views.pop_front();
					if (got.read_tile !== want.read_tile)
						report_mismatch("read_tile", 32'(got.read_tile),
							32'(want.read_tile));
					if (got.dirty_flag !== want.dirty_flag)
						report_mismatch("dirty_flag", 32'(got.dirty_flag),
							32'(want.dirty_flag));
					if (got.rect_x !== want.rect_x)
						report_mismatch("rect_x", 32'(got.rect_x), 32'(want.rect_x));
					if (got.rect_y !== want.rect_y)
						report_mismatch("rect_y", 32'(got.rect_y), 32'(want.rect_y));
					if (got.rect_width !== want.rect_width)
						report_mismatch("rect_width", 32'(got.rect_width),
							32'(want.rect_width));
					if (got.rect_height !== want.rect_height)
						report_mismatch("rect_height", 32'(got.rect_height),
							32'(want.rect_height));
				end
				checked_count++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = apply_tile_op(op_t'(s_axis_tuser), s_axis_tdata[10:0],
					s_axis_tdata[21:11], s_axis_tdata[37:22]);
				expected_views.push_back(tx_typed ? tx_view : want);
				accepted_in <= accepted_in + 1;
			end else if (s_axis_tvalid && accepted_in > 0) begin
				bp_cycles <= bp_cycles + 1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAP_WIDTH:  map_w_reg = cfg_data[7:0];
					CFG_MAP_HEIGHT: map_h_reg = cfg_data[7:0];
					CFG_EMPTY_TILE: empty_reg = cfg_data;
					default: ;
				endcase
				regs_written <= regs_written + 1;
			end
		end
	end

	initial begin : stimulus
		int phase_w [PHASES] = '{8, 128, 1, 16, 0, 128, 3, 200};
		int phase_h [PHASES] = '{8, 128, 1, 4, 5, 1, 128, 130};
		logic [15:0] phase_e [PHASES] = '{16'h0000, 16'hFFFF, 16'h1357, 16'hA5A5,
			16'h0F0F, 16'h8001, 16'h7FFE, 16'hC3C3};
		tile_view_t clean;
		int p, n, r, ew, eh, x, y, scheme, waited;
		logic [15:0] v;
		op_t op;

		for (int i = 0; i < STORE_COLS * STORE_ROWS; i++) tile_mem[i] = '0;
		clean = view(16'h0000, 1'b0, 0, 0, 0, 0);

		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_READ;
		m_axis_tready <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= CFG_MAP_WIDTH;
		cfg_data      <= '0;
		tx_typed      <= 1'b0;
		tx_view       <= '0;
		arst_n        <= 1'b0;

		add_word(OP_READ,  0, 0, 16'h0000, 1, view(16'h0000, 1, 0, 0, 128, 128));
		add_word(OP_CLEAR, 0, 0, 16'h0000, 1, clean);
		add_word(OP_READ,  -1024, -1024, 16'h0000, 1, clean);
		add_word(OP_WRITE, 127, 127, 16'hFFFF, 1, view(16'h0000, 1, 127, 127, 1, 1));
		add_word(OP_WRITE, 0, 0, 16'h0001, 1, view(16'h0000, 1, 0, 0, 128, 128));
		// same value again leaves the rectangle alone
		add_word(OP_WRITE, 0, 0, 16'h0001, 1, view(16'h0000, 1, 0, 0, 128, 128));
		add_word(OP_READ,  127, 127, 16'h0000, 1, view(16'hFFFF, 1, 0, 0, 128, 128));
		add_word(OP_CLEAR, 0, 0, 16'h0000, 1, clean);
		add_word(OP_WRITE, 128, 0, 16'h0005, 1, clean);
		add_word(OP_WRITE, 0, 128, 16'h0005, 1, clean);
		add_word(OP_WRITE, 1023, 1023, 16'hAAAA, 1, clean);
		add_word(OP_WRITE, -1, 5, 16'h0007, 1, clean);
		add_word(OP_WRITE, 5, 5, 16'h0000, 1, clean);
		add_word(OP_WRITE, 64, 32, 16'h5555, 1, view(16'h0000, 1, 64, 32, 1, 1));
		add_word(OP_WRITE, 10, 100, 16'h1234, 0, '0);
		add_word(OP_READ,  64, 32, 16'h0000, 0, '0);
		add_word(OP_READ,  -1, 0, 16'h0000, 0, '0);
		add_word(OP_MARK,  0, 0, 16'h0000, 1, view(16'h0000, 1, 0, 0, 128, 128));
		// zero width: everything out of bounds, mark gives a zero x span
		add_reg(CFG_MAP_WIDTH, 16'h0000);
		add_word(OP_MARK,  0, 0, 16'h0000, 1, view(16'h0000, 1, 0, 0, 0, 128));
		add_word(OP_READ,  0, 0, 16'h0000, 1, view(16'h0000, 1, 0, 0, 0, 128));
		add_reg(CFG_EMPTY_TILE, 16'hBEEF);
		add_word(OP_READ,  -5, 3, 16'h0000, 0, '0);
		add_word(OP_WRITE, 3, 3, 16'h0009, 0, '0);
		// oversized map saturates
		add_reg(CFG_MAP_WIDTH, 16'h00C8);
		add_reg(CFG_MAP_HEIGHT, 16'h00FF);
		add_word(OP_MARK,  0, 0, 16'h0000, 1, view(16'h0000, 1, 0, 0, 128, 128));
		add_word(OP_READ,  127, 127, 16'h0000, 0, '0);
		add_reg(CFG_MAP_WIDTH, 16'hFF40);
		add_reg(CFG_MAP_HEIGHT, 16'h0001);
		add_word(OP_MARK,  0, 0, 16'h0000, 0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG)
				write_reg(dir_rows[i].reg_idx, dir_rows[i].data);
			else
				drive_word(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].data,
					dir_rows[i].typed, dir_rows[i].view);
		end

		for (p = 0; p < PHASES; p++) begin
			write_reg(CFG_MAP_WIDTH, 16'(phase_w[p]));
			write_reg(CFG_MAP_HEIGHT, 16'(phase_h[p]));
			write_reg(CFG_EMPTY_TILE, phase_e[p]);
			ew = (phase_w[p] > STORE_COLS) ? STORE_COLS : phase_w[p];
			eh = (phase_h[p] > STORE_ROWS) ? STORE_ROWS : phase_h[p];
			scheme = p % 4;
			tx_idle_pct  = (scheme == 1) ? 62 : (scheme == 3) ? 34 : 0;
			rx_stall_pct = (scheme == 2) ? 62 : (scheme == 3) ? 34 : 0;
			for (n = 0; n < PHASE_WORDS; n++) begin
				r = $urandom_range(99);
				v = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
				x = pick_coord(ew);
				y = pick_coord(eh);
				if (r < 55) begin
					op = OP_WRITE;
				end else if (r < 80) begin
					op = OP_READ;
				end else if (r < 85) begin
					op = OP_CLEAR;
				end else if (r < 88) begin
					op = OP_MARK;
				end else begin
					// noise over the full field ranges
					op = op_t'($urandom_range(3));
					x = $signed(11'($urandom));
					y = $signed(11'($urandom));
					v = 16'($urandom);
				end
				drive_word(op, x, y, v, 0, '0);
			end
		end
		s_axis_tvalid <= 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;

		waited = 0;
		while (expected_views.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_views.size() != 0) begin
			$display("%0d results never arrived", expected_views.size());
			error_count++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d input words and %0d result words over %0d register writes",
			accepted_in, checked_count, regs_written);
		$display("input held off by back pressure for %0d cycles, %0d mismatches",
			bp_cycles, error_count);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
